// ===== rtl/tmo_pkg.sv =====
// Shared types and constants for the trimmed-mean oversampler.
// Used by tmo_window, tmo_div and trimmed_mean_oversampler_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmo_pkg;

   // Register map: byte addresses of the configuration registers
   localparam logic [1:0] CSR_ADDR_SAMPLE_COUNT = 2'd0;
   localparam int         SAMPLE_COUNT_W        = 7;
   localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RESET = 7'd1;

   // Samples dropped from a window when trimming (one largest, one smallest)
   localparam int TRIM_COUNT = 2;

   // Sequencer to window accumulator
   typedef struct packed {
      logic update;  // take one read attempt
      logic ok;      // the attempt succeeded
      logic clear;   // window closed, restart
   } win_ctrl_type;

   // Divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage : tmo_pkg

`default_nettype wire

// ===== rtl/tmo_window.sv =====
// Window accumulator: running sum, extremes and good/failed read counts.
// Presents the trimmed dividend and divisor for the closing divide. Uses tmo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmo_window #(
   parameter int SB = 12,
   parameter int CW = 7,
   parameter int SW = SB + CW
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tmo_pkg::win_ctrl_type ctrl,
   input  wire logic [SB-1:0]         sample,
   output logic [CW-1:0]              good_count,
   output logic [CW-1:0]              fail_count,
   output logic [SW-1:0]              dividend,
   output logic [CW-1:0]              divisor
);
   import tmo_pkg::*;

   logic [SW-1:0] sum_ff,  sum_in;
   logic [SB-1:0] max_ff,  max_in;
   logic [SB-1:0] min_ff,  min_in;
   logic [CW-1:0] good_ff, good_in;
   logic [CW-1:0] fail_ff, fail_in;
   logic          trim;

   // Next window state
   always_comb begin
      sum_in  = sum_ff;
      max_in  = max_ff;
      min_in  = min_ff;
      good_in = good_ff;
      fail_in = fail_ff;
      if (ctrl.clear) begin
         sum_in  = '0;
         max_in  = '0;
         min_in  = '1;
         good_in = '0;
         fail_in = '0;
      end else if (ctrl.update) begin
         if (ctrl.ok) begin
            sum_in  = sum_ff + SW'(sample);
            good_in = good_ff + CW'(1);
            if (sample > max_ff) max_in = sample;
            if (sample < min_ff) min_in = sample;
         end else begin
            fail_in = fail_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         max_ff  <= '0;
         min_ff  <= '1;
         good_ff <= '0;
         fail_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         max_ff  <= max_in;
         min_ff  <= min_in;
         good_ff <= good_in;
         fail_ff <= fail_in;
      end
   end

   // Drop the extremes only when more than two samples were taken
   assign trim       = (int'(good_ff) > TRIM_COUNT);
   assign dividend   = trim ? (sum_ff - SW'(max_ff) - SW'(min_ff)) : sum_ff;
   assign divisor    = trim ? (good_ff - CW'(TRIM_COUNT)) : good_ff;
   assign good_count = good_ff;
   assign fail_count = fail_ff;

endmodule : tmo_window

`default_nettype wire

// ===== rtl/tmo_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Used by the sequencer for every window that closes on the good count. Uses tmo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmo_div #(
   parameter int DW = 19,
   parameter int VW = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DW-1:0]         dividend,
   input  wire logic [VW-1:0]         divisor,
   output tmo_pkg::div_stat_type      stat,
   output logic [DW-1:0]              quotient
);
   import tmo_pkg::*;

   localparam int NW = $clog2(DW + 1);

   logic [DW-1:0] work_ff, work_in;   // dividend bits out, quotient bits in
   logic [VW-1:0] rem_ff,  rem_in;
   logic [VW-1:0] dsr_ff,  dsr_in;
   logic [NW-1:0] cnt_ff,  cnt_in;
   logic [VW:0]   rem_shift;
   logic          ge;

   // One restoring step
   assign rem_shift = {rem_ff, work_ff[DW-1]};
   assign ge        = (rem_shift >= {1'b0, dsr_ff});

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = NW'(DW);
      end else if (cnt_ff != '0) begin
         work_in = {work_ff[DW-2:0], ge};
         rem_in  = ge ? VW'(rem_shift - {1'b0, dsr_ff}) : rem_shift[VW-1:0];
         cnt_in  = cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = (cnt_ff == NW'(1));
   assign quotient  = work_in;

endmodule : tmo_div

`default_nettype wire

// ===== rtl/trimmed_mean_oversampler_top.sv =====
// Trimmed-mean oversampler: stream in, one result beat per closed window.
// Depends on tmo_pkg, tmo_window and tmo_div.
//
// Each input beat is one converter read attempt (tuser = read ok, tdata = raw code).
// Good reads add to a running sum with min/max tracking; failed reads are counted.
// A window closes when the good or the failed count reaches sample_count (0 acts as
// 1, values above MAX_SAMPLES act as MAX_SAMPLES). A failed window gives failed = 1
// and average 0; otherwise the largest and smallest are dropped when more than two
// samples were taken and the truncated mean is returned. Each beat passes the accept
// and check states; a failing close adds the emit state, and a good close adds the
// divide state, where the serial divider retires one quotient bit per cycle, then
// the emit state, which waits for the output register to be free. req_tready is low
// while a beat is in work; a finished result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module trimmed_mean_oversampler_top #(
   parameter int SAMPLE_BITS = 12,
   parameter int MAX_SAMPLES = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,  // raw_sample
   input  wire logic                                req_tuser,  // read_ok
   // result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]         rsp_tdata,  // average
   output logic                                     rsp_tuser,  // failed
   // configuration
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [1:0]                          csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);
   import tmo_pkg::*;

   localparam int CW     = $clog2(MAX_SAMPLES + 1);
   localparam int SW     = SAMPLE_BITS + CW;
   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type                 state_ff;
   logic [SAMPLE_COUNT_W-1:0] sample_count_ff;
   logic                      ok_ff;
   logic [SAMPLE_BITS-1:0]    res_avg_ff;
   logic                      res_failed_ff;
   logic                      rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]    rsp_avg_ff;
   logic                      rsp_failed_ff;

   win_ctrl_type              win_ctrl;
   div_stat_type              div_stat;
   logic [CW-1:0]             good_count;
   logic [CW-1:0]             fail_count;
   logic [SW-1:0]             dividend;
   logic [CW-1:0]             divisor;
   logic [SW-1:0]             quotient;
   logic [CW-1:0]             limit;
   logic                      csr_wr;
   logic                      req_beat;
   logic                      out_free;
   logic                      good_close;
   logic                      fail_close;
   logic                      div_start;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RESET;
      end else if (csr_wr && csr_paddr == CSR_ADDR_SAMPLE_COUNT) begin
         sample_count_ff <= csr_pwdata[SAMPLE_COUNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == CSR_ADDR_SAMPLE_COUNT) ?
                       32'(sample_count_ff) : 32'd0;

   // Effective window length
   always_comb begin
      if (sample_count_ff == '0) begin
         limit = CW'(1);
      end else if (int'(sample_count_ff) > MAX_SAMPLES) begin
         limit = CW'(MAX_SAMPLES);
      end else begin
         limit = CW'(sample_count_ff);
      end
   end

   // Handshake and sequencer decisions
   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fail_close = (state_ff == ST_CHECK) && !ok_ff && (fail_count >= limit);
   assign good_close = (state_ff == ST_CHECK) && ok_ff && (good_count >= limit);
   assign div_start  = good_close;

   assign win_ctrl.update = req_beat;
   assign win_ctrl.ok     = req_tuser;
   assign win_ctrl.clear  = (state_ff == ST_EMIT) && out_free;

   tmo_window #(
      .SB (SAMPLE_BITS),
      .CW (CW),
      .SW (SW)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (win_ctrl),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .good_count (good_count),
      .fail_count (fail_count),
      .dividend   (dividend),
      .divisor    (divisor)
   );

   tmo_div #(
      .DW (SW),
      .VW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // Sequencer and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  ok_ff    <= req_tuser;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (fail_close) begin
                  res_avg_ff    <= '0;
                  res_failed_ff <= 1'b1;
                  state_ff      <= ST_EMIT;
               end else if (good_close) begin
                  state_ff <= ST_DIVIDE;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIVIDE: begin
               if (div_stat.done) begin
                  res_avg_ff    <= quotient[SAMPLE_BITS-1:0];
                  res_failed_ff <= 1'b0;
                  state_ff      <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_avg_ff    <= res_avg_ff;
                  rsp_failed_ff <= res_failed_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_avg_ff);
   assign rsp_tuser  = rsp_failed_ff;

`ifndef SYNTHESIS
   // divider is never restarted mid-divide
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // divider keeps running for the whole divide phase
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> div_stat.busy)
      else $error("divide phase without divider activity");

   // a new result beat only follows the emit phase
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result beat raised outside emit");

   // a failed window carries a zero average
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_failed_ff) |-> (rsp_avg_ff == '0))
      else $error("failed result with non-zero average");

   // window clear empties both counts
   assert property (@(posedge clock) disable iff (reset)
      win_ctrl.clear |=> (good_count == '0 && fail_count == '0))
      else $error("window counts not cleared");
`endif

endmodule : trimmed_mean_oversampler_top

`default_nettype wire

// ===== bench/tb_trimmed_mean_oversampler_top.sv =====
// Self-checking bench for trimmed_mean_oversampler_top: stream beats in, window results out.
// Depends on tmo_pkg and the oversampler RTL; a beat-level predictor checks every result beat.
`timescale 1ns / 1ps

module tb_trimmed_mean_oversampler_top;
   import tmo_pkg::*;

   localparam int SAMPLE_BITS   = 12;
   localparam int MAX_SAMPLES   = 64;
   localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_BEATS  = 1000;

   typedef enum logic [1:0] {STEP_READING, STEP_SET_LIMIT, STEP_HOLD_OFF} step_kind_type;
   typedef enum logic [1:0] {DRV_FETCH, DRV_SETTLE, DRV_SETUP, DRV_ACCESS} drv_state_type;

   typedef struct {
      step_kind_type          kind;
      logic                   read_ok;
      logic [SAMPLE_BITS-1:0] raw;
      logic [SAMPLE_COUNT_W-1:0] limit;
      int unsigned            gap;
   } step_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] average;
      logic                   failed;
   } window_result_type;

   // DUT connections, all inputs known from time zero
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;   // [11:0] raw_sample
   logic              req_tuser = 1'b0; // [0] read_ok
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;        // [11:0] average
   logic              rsp_tuser;        // [0] failed
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [1:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   trimmed_mean_oversampler_top #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_SAMPLES(MAX_SAMPLES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Clock, reset and cycle count
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Predictor state: the window accumulator and the programmed limit
   logic [SAMPLE_COUNT_W-1:0] limit_reg = SAMPLE_COUNT_RESET;
   logic [17:0]               acc_sum;
   logic [SAMPLE_BITS-1:0]    acc_max;
   logic [SAMPLE_BITS:0]      acc_min;   // one above full scale when empty
   logic [6:0]                n_good;
   logic [6:0]                n_fail;

   window_result_type expected_means[$];
   step_type          script_q[$];
   step_type          held_step;
   drv_state_type     drv_state = DRV_FETCH;

   int unsigned gap_left = 0;
   int unsigned settle_left = 0;
   int unsigned stall_left = 0;
   bit          script_done = 1'b0;
   int          error_count = 0;
   int          beats_taken = 0;
   int          windows_closed = 0;
   int          windows_failed = 0;
   int          limit_writes = 0;

   task automatic restart_window();
      acc_sum = '0;
      acc_max = '0;
      acc_min = {1'b1, {SAMPLE_BITS{1'b0}}};
      n_good  = '0;
      n_fail  = '0;
   endtask

   initial restart_window();

   // Fold one accepted read attempt into the window; queue a result if it closes
   task automatic fold_reading(input logic ok, input logic [SAMPLE_BITS-1:0] raw);
      logic [6:0]        lim;
      logic [17:0]       total;
      logic [6:0]        divisor;
      window_result_type res;
      lim = (limit_reg == 0) ? 7'd1 : (limit_reg > MAX_SAMPLES) ? 7'(MAX_SAMPLES) : limit_reg;
      if (!ok) begin
         n_fail = n_fail + 7'd1;
         if (n_fail >= lim) begin
            res.average = '0;
            res.failed  = 1'b1;
            expected_means.push_back(res);
            restart_window();
         end
      end else begin
         if (raw > acc_max) acc_max = raw;
         if ({1'b0, raw} < acc_min) acc_min = {1'b0, raw};
         acc_sum = acc_sum + 18'(raw);
         n_good  = n_good + 7'd1;
         if (n_good >= lim) begin
            total   = acc_sum;
            divisor = n_good;
            // drop the extremes only when something is left to average
            if (divisor > TRIM_COUNT) begin
               total   = total - 18'(acc_max) - 18'(acc_min[SAMPLE_BITS-1:0]);
               divisor = divisor - 7'(TRIM_COUNT);
            end
            res.average = SAMPLE_BITS'(total / divisor);
            res.failed  = 1'b0;
            expected_means.push_back(res);
            restart_window();
         end
      end
   endtask

   // Pauses: mostly short, now and then long
   function automatic int unsigned draw_pause();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 4);
      return $urandom_range(12, 60);
   endfunction

   task automatic add_reading(input logic ok, input int unsigned raw, input int unsigned gap);
      step_type s;
      s.kind    = STEP_READING;
      s.read_ok = ok;
      s.raw     = raw[SAMPLE_BITS-1:0];
      s.limit   = '0;
      s.gap     = gap;
      script_q.push_back(s);
   endtask

   task automatic add_control(input step_kind_type kind, input int unsigned value);
      step_type s;
      s.kind    = kind;
      s.read_ok = 1'b0;
      s.raw     = '0;
      s.limit   = value[SAMPLE_COUNT_W-1:0];
      s.gap     = 0;
      script_q.push_back(s);
   endtask

   // Driver: feeds read beats from the script, does register writes while idle
   always @(posedge clock) begin : driver
      step_type s;
      logic     hold_valid;
      if (reset) begin
         req_tvalid  <= 1'b0;
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         drv_state   <= DRV_FETCH;
         gap_left = 0;
      end else begin
         hold_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            fold_reading(req_tuser, req_tdata[SAMPLE_BITS-1:0]);
            beats_taken++;
            hold_valid = 1'b0;
         end
         if (!hold_valid) begin
            case (drv_state)
               DRV_FETCH: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else if (script_q.size() == 0) begin
                     script_done = 1'b1;
                  end else begin
                     s = script_q.pop_front();
                     if (s.kind == STEP_READING) begin
                        hold_valid = 1'b1;
                        req_tuser <= s.read_ok;
                        req_tdata <= DATA_W'(s.raw);
                        gap_left = s.gap;
                     end else begin
                        held_step   = s;
                        settle_left = SETTLE_CYCLES;
                        drv_state  <= DRV_SETTLE;
                     end
                  end
               end
               // wait for every result, then for the block to go quiet
               DRV_SETTLE: begin
                  if (expected_means.size() != 0) begin
                     settle_left = SETTLE_CYCLES;
                  end else if (settle_left > 0) begin
                     settle_left--;
                  end else if (held_step.kind == STEP_SET_LIMIT) begin
                     csr_psel   <= 1'b1;
                     csr_pwrite <= 1'b1;
                     csr_paddr  <= CSR_ADDR_SAMPLE_COUNT;
                     csr_pwdata <= 32'(held_step.limit);
                     drv_state  <= DRV_SETUP;
                  end else begin
                     drv_state <= DRV_FETCH;
                  end
               end
               DRV_SETUP: begin
                  csr_penable <= 1'b1;
                  drv_state   <= DRV_ACCESS;
               end
               DRV_ACCESS: begin
                  if (csr_pready) begin
                     csr_psel    <= 1'b0;
                     csr_penable <= 1'b0;
                     csr_pwrite  <= 1'b0;
                     limit_reg = csr_pwdata[SAMPLE_COUNT_W-1:0];
                     limit_writes++;
                     drv_state <= DRV_FETCH;
                  end
               end
               default: drv_state <= DRV_FETCH;
            endcase
         end
         req_tvalid <= hold_valid;
      end
   end

   // Monitor: checks each result beat against the oldest prediction, drives back-pressure
   always @(posedge clock) begin : monitor
      window_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_means.size() == 0) begin
               $error("result beat with nothing pending: average %0d failed %0d",
                      rsp_tdata[SAMPLE_BITS-1:0], rsp_tuser);
               error_count++;
            end else begin
               want = expected_means.pop_front();
               windows_closed++;
               if (want.failed) windows_failed++;
               if (rsp_tdata[SAMPLE_BITS-1:0] !== want.average) begin
                  $error("average: expected %0d, got %0d", want.average,
                         rsp_tdata[SAMPLE_BITS-1:0]);
                  error_count++;
               end
               if (rsp_tuser !== want.failed) begin
                  $error("failed: expected %0d, got %0d", want.failed, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (cycle_count[10:9] == 2'b00) begin
            rsp_tready <= 1'b1;   // stretch with no back-pressure
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = draw_pause();
            rsp_tready <= 1'b0;
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("trimmed_mean_oversampler_top test failed");
      $finish;
   end

   // Script: directed cases, then random phases of limit settings
   initial begin : stimulus
      int          random_beats;
      int unsigned lim_value;
      int unsigned eff_limit;
      int unsigned n_items;
      int unsigned fail_pct;
      int unsigned raw_style;
      int unsigned centre;
      int unsigned raw;
      bit          steady;
      int          extremes[7];
      extremes = '{0, 1, 2, 3, 64, 65, 127};
      random_beats = 0;

      // limit of one after reset: every beat closes a window
      add_reading(1'b1, 0, 0);
      add_reading(1'b1, 4095, 3);
      add_reading(1'b0, 12'hABC, 0);
      // three samples: top and bottom dropped
      add_control(STEP_SET_LIMIT, 3);
      add_reading(1'b1, 4095, 0);
      add_reading(1'b1, 0, 0);
      add_reading(1'b1, 2048, 0);
      // two samples: plain mean, no trimming
      add_control(STEP_SET_LIMIT, 2);
      add_reading(1'b1, 4095, 0);
      add_reading(1'b1, 4095, 0);
      // zero limit acts as one
      add_control(STEP_SET_LIMIT, 0);
      add_reading(1'b1, 1234, 0);
      add_reading(1'b0, 4095, 0);
      // failures win the race against good samples
      add_control(STEP_SET_LIMIT, 3);
      add_reading(1'b0, 0, 0);
      add_reading(1'b1, 5, 0);
      add_reading(1'b0, 4095, 0);
      add_reading(1'b0, 0, 0);
      // limit lowered mid-window on the good count
      add_control(STEP_SET_LIMIT, 8);
      add_reading(1'b1, 100, 0);
      add_reading(1'b1, 200, 0);
      add_reading(1'b1, 300, 0);
      add_reading(1'b1, 400, 0);
      add_reading(1'b0, 0, 0);
      add_reading(1'b0, 0, 0);
      add_control(STEP_HOLD_OFF, 0);
      add_control(STEP_SET_LIMIT, 2);
      add_reading(1'b1, 4000, 0);
      // and on the failed count
      add_control(STEP_SET_LIMIT, 8);
      add_reading(1'b0, 0, 0);
      add_reading(1'b0, 0, 0);
      add_reading(1'b0, 0, 0);
      add_control(STEP_SET_LIMIT, 2);
      add_reading(1'b0, 0, 0);

      // random phases; a phase may end mid-window so the next limit lands on live state
      while (random_beats < RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0:       lim_value = extremes[$urandom_range(0, 6)];
            1, 2, 3, 4, 5: lim_value = $urandom_range(1, 8);
            6, 7:    lim_value = $urandom_range(9, 32);
            default: lim_value = $urandom_range(33, 64);
         endcase
         add_control(STEP_SET_LIMIT, lim_value);
         eff_limit = (lim_value == 0) ? 1 : (lim_value > MAX_SAMPLES) ? MAX_SAMPLES : lim_value;
         n_items   = eff_limit * $urandom_range(1, 4) + $urandom_range(0, 3);
         fail_pct  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 10);
         steady    = ($urandom_range(0, 3) == 0);
         raw_style = $urandom_range(0, 2);
         centre    = $urandom_range(0, 4095);
         repeat (n_items) begin
            case (raw_style)
               0: raw = $urandom_range(0, 4095);
               1: raw = (centre + $urandom_range(0, 63)) & 12'hFFF;
               default: raw = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) :
                              ($urandom_range(0, 1) ? 4095 : 0);
            endcase
            add_reading($urandom_range(0, 99) >= fail_pct, raw,
                        (steady || $urandom_range(0, 1)) ? 0 : draw_pause());
            random_beats++;
         end
         if ($urandom_range(0, 4) == 0) add_control(STEP_HOLD_OFF, 0);
      end

      wait (script_done);
      while (expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d read beats and %0d limit writes; %0d windows closed, %0d on failure.",
               beats_taken, limit_writes, windows_closed, windows_failed);
      if (error_count == 0 && expected_means.size() == 0) begin
         $display("trimmed_mean_oversampler_top test passed");
      end else begin
         $display("trimmed_mean_oversampler_top test failed");
      end
      $finish;
   end

endmodule : tb_trimmed_mean_oversampler_top

// ===== filelist.f =====
rtl/tmo_pkg.sv
rtl/tmo_window.sv
rtl/tmo_div.sv
rtl/trimmed_mean_oversampler_top.sv
bench/tb_trimmed_mean_oversampler_top.sv
